// ===== sv/radar_measurement_jacobian_assert.svh =====
// Assertion macros for the radar measurement Jacobian block.
`ifndef RADAR_MEASUREMENT_JACOBIAN_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RMJ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define RMJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rmj_pkg.sv =====
// Shared constants and types for the radar measurement Jacobian block.
`default_nettype none

package rmj_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned EPS_W     = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  // square root of a 64-bit sum of squares, one result bit per stage
  localparam int unsigned SQ_W = 2 * IN_W;
  localparam int unsigned SQ_N = SQ_W / 2;

  // divider operand widths
  localparam int unsigned NUM_RANGE_W = IN_W + FRAC_BITS;
  localparam int unsigned DEN_RANGE_W = OUT_W;
  localparam int unsigned NUM_BEAR_W  = IN_W + 2 * FRAC_BITS;
  localparam int unsigned DEN_BEAR_W  = SQ_W;
  localparam int unsigned RATE_W      = SQ_W + OUT_W;
  localparam int unsigned NUM_RATE_W  = RATE_W + FRAC_BITS;
  localparam int unsigned DEN_RATE_W  = RATE_W;

  localparam int unsigned DIV_LAT  = OUT_W + 2;
  localparam int unsigned PIPE_LAT = 4 + SQ_N + 2 + DIV_LAT;

  localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [IN_W-1:0] mx;
    logic [IN_W-1:0] my;
    logic            pxn;
    logic            pyn;
    logic            cneg;
    logic            fault;
    logic [SQ_W-1:0] cmag;
    logic [SQ_W-1:0] s;
  } side_t;

endpackage

`default_nettype wire

// ===== sv/radar_measurement_jacobian.sv =====
// Top level of the radar measurement Jacobian pipeline.
`default_nettype none
`include "radar_measurement_jacobian_assert.svh"

// Radar measurement Jacobian for a constant-velocity state (px, py, vx, vy), signed
// Q16.16. Gives range, bearing and range-rate derivatives (the repeated row-2 entries
// equal drange_dpx/drange_dpy). One item per clock while the skid entry is empty. Stages from
// accept to result: four input/product stages, a 32-stage square root (one result bit per
// stage), two multiply stages for s*r and the rate numerators, six parallel
// 34-stage dividers that give one quotient bit per stage, then the output register.
// An output register plus a skid entry keep input flowing after the output stalls until
// the skid entry fills. When the cross term is under cross_epsilon or px or py is zero,
// all entries are zero and tuser (fault) is set. cross_epsilon resets to 1 and may be
// written only while idle.
module radar_measurement_jacobian (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rmj_pkg::EPS_W-1:0]    cfg_data_i,     // cross_epsilon
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [4*rmj_pkg::IN_W-1:0]   s_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // drange_dpx, drange_dpy, dbearing_dpx, dbearing_dpy, drate_dpx, drate_dpy
  output logic [6*rmj_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                         m_axis_tuser    // fault
);
  import rmj_pkg::*;

  logic [EPS_W-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  logic en;
  logic out_vld_q, skid_vld_q;
  logic [PIPE_LAT-1:0] vld_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  // input register
  logic [IN_W-1:0] px_in, py_in, vx_in, vy_in;
  logic signed [IN_W-1:0] px0_q, py0_q, vx0_q, vy0_q;
  logic [IN_W-1:0] mx0_q, my0_q;

  assign px_in = s_axis_tdata[IN_W-1:0];
  assign py_in = s_axis_tdata[2*IN_W-1:IN_W];
  assign vx_in = s_axis_tdata[3*IN_W-1:2*IN_W];
  assign vy_in = s_axis_tdata[4*IN_W-1:3*IN_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_q <= px_in;
      py0_q <= py_in;
      vx0_q <= vx_in;
      vy0_q <= vy_in;
      mx0_q <= px_in[IN_W-1] ? (~px_in + 1'b1) : px_in;
      my0_q <= py_in[IN_W-1] ? (~py_in + 1'b1) : py_in;
    end
  end

  // products
  logic signed [SQ_W-1:0] a1_q, b1_q;
  logic [SQ_W-1:0] sqx1_q, sqy1_q;
  logic [IN_W-1:0] mx1_q, my1_q;
  logic            pxn1_q, pyn1_q, zero1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q    <= vx0_q * py0_q;
      b1_q    <= vy0_q * px0_q;
      sqx1_q  <= mx0_q * mx0_q;
      sqy1_q  <= my0_q * my0_q;
      mx1_q   <= mx0_q;
      my1_q   <= my0_q;
      pxn1_q  <= px0_q[IN_W-1];
      pyn1_q  <= py0_q[IN_W-1];
      zero1_q <= (px0_q == '0) || (py0_q == '0);
    end
  end

  // sum of squares and cross term vx*py - vy*px
  logic [SQ_W-1:0] s2_q;
  logic [SQ_W:0]   dif2_q;
  logic [IN_W-1:0] mx2_q, my2_q;
  logic            pxn2_q, pyn2_q, zero2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q    <= sqx1_q + sqy1_q;
      dif2_q  <= {a1_q[SQ_W-1], a1_q} - {b1_q[SQ_W-1], b1_q};
      mx2_q   <= mx1_q;
      my2_q   <= my1_q;
      pxn2_q  <= pxn1_q;
      pyn2_q  <= pyn1_q;
      zero2_q <= zero1_q;
    end
  end

  // cross magnitude
  logic [SQ_W-1:0] s3_q, cmag3_q;
  logic [IN_W-1:0] mx3_q, my3_q;
  logic            pxn3_q, pyn3_q, zero3_q, cneg3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q    <= s2_q;
      cneg3_q <= dif2_q[SQ_W];
      cmag3_q <= dif2_q[SQ_W] ? SQ_W'(~dif2_q + 1'b1) : dif2_q[SQ_W-1:0];
      mx3_q   <= mx2_q;
      my3_q   <= my2_q;
      pxn3_q  <= pxn2_q;
      pyn3_q  <= pyn2_q;
      zero3_q <= zero2_q;
    end
  end

  side_t side0;

  always_comb begin
    side0.mx    = mx3_q;
    side0.my    = my3_q;
    side0.pxn   = pxn3_q;
    side0.pyn   = pyn3_q;
    side0.cneg  = cneg3_q;
    side0.fault = zero3_q || (cmag3_q < (SQ_W'(eps_q) << FRAC_BITS));
    side0.cmag  = cmag3_q;
    side0.s     = s3_q;
  end

  // integer square root, one result bit per stage
  logic [SQ_W-1:0] sq_x_q   [1:SQ_N-1];
  logic [SQ_W-1:0] sq_res_q [1:SQ_N];
  side_t           sd_q     [1:SQ_N];

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] ONE = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] x_in, res_in;
    side_t           sd_in;
    logic [SQ_W:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign x_in   = s3_q;
      assign res_in = '0;
      assign sd_in  = side0;
    end else begin : g_rest
      assign x_in   = sq_x_q[k];
      assign res_in = sq_res_q[k];
      assign sd_in  = sd_q[k];
    end

    assign trial = {1'b0, res_in} + {1'b0, ONE};
    assign take  = ({1'b0, x_in} >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_res_q[k+1] <= take ? ((res_in >> 1) + ONE) : (res_in >> 1);
        sd_q[k+1]     <= sd_in;
      end
    end

    if (k < SQ_N - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en) begin
          sq_x_q[k+1] <= take ? (x_in - trial[SQ_W-1:0]) : x_in;
        end
      end
    end
  end

  // partial products of s*r and of the rate numerators
  logic [OUT_W-1:0]   r_m, r1_q, r2_q;
  side_t              sd_m, sd1_q, sd2_q;
  logic [2*OUT_W-1:0] srl1_q, srh1_q, ycl1_q, ych1_q, xcl1_q, xch1_q;
  logic [RATE_W-1:0]  sr2_q, ymc2_q, xmc2_q;

  assign r_m  = sq_res_q[SQ_N][OUT_W-1:0];
  assign sd_m = sd_q[SQ_N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      srl1_q <= sd_m.s[OUT_W-1:0] * r_m;
      srh1_q <= sd_m.s[SQ_W-1:OUT_W] * r_m;
      ycl1_q <= sd_m.my * sd_m.cmag[OUT_W-1:0];
      ych1_q <= sd_m.my * sd_m.cmag[SQ_W-1:OUT_W];
      xcl1_q <= sd_m.mx * sd_m.cmag[OUT_W-1:0];
      xch1_q <= sd_m.mx * sd_m.cmag[SQ_W-1:OUT_W];
      r1_q   <= r_m;
      sd1_q  <= sd_m;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr2_q  <= (RATE_W'(srh1_q) << OUT_W) + RATE_W'(srl1_q);
      ymc2_q <= (RATE_W'(ych1_q) << OUT_W) + RATE_W'(ycl1_q);
      xmc2_q <= (RATE_W'(xch1_q) << OUT_W) + RATE_W'(xcl1_q);
      r2_q   <= r1_q;
      sd2_q  <= sd1_q;
    end
  end

  // dividers
  logic [OUT_W-1:0] q_rx, q_ry, q_bx, q_by, q_vx, q_vy;

  rmj_div #(.NUM_W(NUM_RANGE_W), .DEN_W(DEN_RANGE_W)) u_div_rx (
    .clk_i, .en_i(en), .neg_i(sd2_q.pxn),
    .num_i({sd2_q.mx, {FRAC_BITS{1'b0}}}), .den_i(r2_q), .quo_o(q_rx)
  );

  rmj_div #(.NUM_W(NUM_RANGE_W), .DEN_W(DEN_RANGE_W)) u_div_ry (
    .clk_i, .en_i(en), .neg_i(sd2_q.pyn),
    .num_i({sd2_q.my, {FRAC_BITS{1'b0}}}), .den_i(r2_q), .quo_o(q_ry)
  );

  rmj_div #(.NUM_W(NUM_BEAR_W), .DEN_W(DEN_BEAR_W)) u_div_bx (
    .clk_i, .en_i(en), .neg_i(!sd2_q.pyn),
    .num_i({sd2_q.my, {(2*FRAC_BITS){1'b0}}}), .den_i(sd2_q.s), .quo_o(q_bx)
  );

  rmj_div #(.NUM_W(NUM_BEAR_W), .DEN_W(DEN_BEAR_W)) u_div_by (
    .clk_i, .en_i(en), .neg_i(sd2_q.pxn),
    .num_i({sd2_q.mx, {(2*FRAC_BITS){1'b0}}}), .den_i(sd2_q.s), .quo_o(q_by)
  );

  rmj_div #(.NUM_W(NUM_RATE_W), .DEN_W(DEN_RATE_W)) u_div_vx (
    .clk_i, .en_i(en), .neg_i(sd2_q.pyn ^ sd2_q.cneg),
    .num_i({ymc2_q, {FRAC_BITS{1'b0}}}), .den_i(sr2_q), .quo_o(q_vx)
  );

  rmj_div #(.NUM_W(NUM_RATE_W), .DEN_W(DEN_RATE_W)) u_div_vy (
    .clk_i, .en_i(en), .neg_i(!(sd2_q.pxn ^ sd2_q.cneg)),
    .num_i({xmc2_q, {FRAC_BITS{1'b0}}}), .den_i(sr2_q), .quo_o(q_vy)
  );

  // fault travels alongside the dividers
  logic [DIV_LAT-1:0] flt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      flt_q <= {flt_q[DIV_LAT-2:0], sd2_q.fault};
    end
  end

  logic [6*OUT_W-1:0] pipe_data;
  logic               pipe_flt, pipe_vld;

  assign pipe_vld  = vld_q[PIPE_LAT-1];
  assign pipe_flt  = flt_q[DIV_LAT-1];
  assign pipe_data = pipe_flt ? '0 : {q_vy, q_vx, q_by, q_bx, q_ry, q_rx};

  // output register with one skid entry
  logic               load;
  logic [6*OUT_W-1:0] out_data_q, skid_data_q;
  logic               out_flt_q, skid_flt_q;

  assign load = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (load) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= pipe_vld;
      end
    end else if (en && pipe_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= skid_vld_q ? skid_data_q : pipe_data;
      out_flt_q  <= skid_vld_q ? skid_flt_q  : pipe_flt;
    end else if (en && pipe_vld) begin
      skid_data_q <= pipe_data;
      skid_flt_q  <= pipe_flt;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_flt_q;

  `RMJ_ASSERT_NOW(a_skid_behind_out, skid_vld_q, out_vld_q, "skid holds an item while output is empty")
  `RMJ_ASSERT_NOW(a_fault_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "faulted item has nonzero data")
  `RMJ_ASSERT_NEXT(a_skid_drains, skid_vld_q && m_axis_tready, !skid_vld_q, "skid did not drain on take")

endmodule

`default_nettype wire

// ===== sv/rmj_div.sv =====
// Pipelined restoring divider: truncating quotient, sign applied, saturated to 32 bits.
`default_nettype none

module rmj_div #(
  parameter int unsigned NUM_W = rmj_pkg::NUM_RATE_W,
  parameter int unsigned DEN_W = rmj_pkg::DEN_RATE_W
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     neg_i,
  input  logic [NUM_W-1:0]         num_i,
  input  logic [DEN_W-1:0]         den_i,
  output logic [rmj_pkg::OUT_W-1:0] quo_o
);
  import rmj_pkg::*;

  localparam int unsigned CW = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  logic [CW-1:0]    hi_c, den_c;
  logic [DEN_W-1:0] rem_q [0:OUT_W-1];
  logic [DEN_W-1:0] den_q [0:OUT_W-1];
  logic [OUT_W-1:0] lo_q  [0:OUT_W-1];
  logic [OUT_W-1:0] quo_q [0:OUT_W];
  logic             ovf_q [0:OUT_W];
  logic             neg_q [0:OUT_W];
  logic [OUT_W-1:0] lim, mag, res_d, res_q;

  // quotient needs more than 32 bits when the upper part already reaches den
  assign hi_c  = CW'(num_i >> OUT_W);
  assign den_c = CW'(den_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DEN_W'(hi_c);
      den_q[0] <= den_i;
      lo_q[0]  <= num_i[OUT_W-1:0];
      quo_q[0] <= '0;
      ovf_q[0] <= (hi_c >= den_c);
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 0; k < OUT_W; k++) begin : g_step
    logic [DEN_W:0] trial, diff;
    logic           take;

    assign trial = {rem_q[k], lo_q[k][OUT_W-1]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign take  = (trial >= {1'b0, den_q[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k+1] <= {quo_q[k][OUT_W-2:0], take};
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end

    if (k < OUT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          den_q[k+1] <= den_q[k];
          lo_q[k+1]  <= lo_q[k] << 1;
        end
      end
    end
  end

  always_comb begin
    lim   = neg_q[OUT_W] ? SAT_NEG : SAT_POS;
    mag   = (ovf_q[OUT_W] || (quo_q[OUT_W] > lim)) ? lim : quo_q[OUT_W];
    res_d = neg_q[OUT_W] ? (~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign quo_o = res_q;

endmodule

`default_nettype wire
